FILE: design/agkf_pkg.sv
// Shared constants and saturation helpers for the angle/gyro Kalman filter.
package agkf_pkg;

   localparam int COV_W   = 48;
   localparam int COV_FRAC = 40;
   localparam logic signed [COV_W-1:0] COV_ONE = 48'sh0100_0000_0000;
   localparam logic signed [COV_W-1:0] COV_MAX = 48'sh7FFF_FFFF_FFFF;

   localparam logic [31:0] QA_RESET = 32'd4294967;
   localparam logic [31:0] QG_RESET = 32'd12884902;
   localparam logic [31:0] RN_RESET = 32'd2147483648;
   localparam logic [31:0] DT_RESET = 32'd21474836;

   // register indexes on the csr port
   localparam logic [1:0] REG_QA = 2'd0;
   localparam logic [1:0] REG_QG = 2'd1;
   localparam logic [1:0] REG_RN = 2'd2;
   localparam logic [1:0] REG_DT = 2'd3;

   function automatic logic signed [COV_W-1:0] sat48(input logic signed [63:0] v);
      logic signed [COV_W-1:0] r;
      if (v > 64'sh0000_7FFF_FFFF_FFFF) r = COV_MAX;
      else if (v < -64'sh0000_8000_0000_0000) r = -COV_MAX - 48'sd1;
      else r = v[COV_W-1:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

FILE: design/angle_gyro_kalman_filter.sv
// A request runs ten rounded multiplies on the shared 32x32 multiplier (start, partial
// products, done), two bit-serial gain divisions (start, quotient steps, done), one prepare
// step and one output step. With E zero the divisions are skipped. A new request is taken
// only once the previous one has finished; a finished result waits in an output register.
// Synchronous reset: angle and bias zero, covariance identity, noise and dt at defaults.
module angle_gyro_kalman_filter import agkf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_angle_meas,
   input  logic signed [31:0] req_gyro_rate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_angle_est,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_MWAIT = 3'd2;
   localparam logic [2:0] ST_PREP  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DWAIT = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam logic [3:0] STEP_LAST_PRED = 4'd3;
   localparam logic [3:0] STEP_FIRST_COR = 4'd4;
   localparam logic [3:0] STEP_LAST      = 4'd9;

   logic [31:0] qa_ff, qa_in, qg_ff, qg_in, rn_ff, rn_in, dt_ff, dt_in;
   logic [2:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic        dsel_ff, dsel_in;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] meas_ff, meas_in, rate_ff, rate_in;
   logic signed [COV_W-1:0] p_ff [4];
   logic signed [COV_W-1:0] p_in [4];
   logic signed [COV_W-1:0] t0_ff, t0_in, t1_ff, t1_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [32:0] err_ff, err_in;
   logic signed [COV_W:0] e_ff, e_in, e_calc;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_ff, rsp_in;

   logic signed [63:0] mul_a, mul_b, mul_res;
   logic        mul_sh40, mul_done, div_done;
   logic signed [COV_W-1:0] div_num, div_res;
   logic        csr_write;

   agkf_mul u_mul (
      .clock, .reset,
      .mul_start (state_ff == ST_MUL),
      .mul_a, .mul_b, .mul_sh40, .mul_done, .mul_res
   );

   agkf_div u_div (
      .clock, .reset,
      .div_start (state_ff == ST_DIV),
      .div_num, .div_den (e_ff), .div_done, .div_res
   );

   assign div_num = dsel_ff ? p_ff[2] : p_ff[0];
   assign csr_write = psel & penable & pwrite;
   assign e_calc = $signed({9'd0, rn_ff, 8'd0}) + (COV_W+1)'(p_ff[0]);

   // operand selection for each multiply step
   always_comb begin
      mul_a = '0;
      mul_b = 64'(dt_ff);
      mul_sh40 = 1'b0;
      case (step_ff)
         4'd0: mul_a = 64'(rate_ff) - 64'(bias_ff);
         4'd1: mul_a = $signed({24'd0, qa_ff, 8'd0}) - 64'(p_ff[1]) - 64'(p_ff[2]);
         4'd2: mul_a = -64'(p_ff[3]);
         4'd3: mul_a = $signed({24'd0, qg_ff, 8'd0});
         4'd4: begin mul_a = 64'(k0_ff); mul_b = 64'(t0_ff); mul_sh40 = 1'b1; end
         4'd5: begin mul_a = 64'(k0_ff); mul_b = 64'(t1_ff); mul_sh40 = 1'b1; end
         4'd6: begin mul_a = 64'(k1_ff); mul_b = 64'(t0_ff); mul_sh40 = 1'b1; end
         4'd7: begin mul_a = 64'(k1_ff); mul_b = 64'(t1_ff); mul_sh40 = 1'b1; end
         4'd8: begin mul_a = 64'(k0_ff); mul_b = 64'(err_ff); mul_sh40 = 1'b1; end
         4'd9: begin mul_a = 64'(k1_ff); mul_b = 64'(err_ff); mul_sh40 = 1'b1; end
         default: mul_a = '0;
      endcase
   end

   always_comb begin
      qa_in = qa_ff; qg_in = qg_ff; rn_in = rn_ff; dt_in = dt_ff;
      state_in = state_ff; step_in = step_ff; dsel_in = dsel_ff;
      angle_in = angle_ff; bias_in = bias_ff; meas_in = meas_ff; rate_in = rate_ff;
      for (int i = 0; i < 4; i++) p_in[i] = p_ff[i];
      t0_in = t0_ff; t1_in = t1_ff; k0_in = k0_ff; k1_in = k1_ff;
      err_in = err_ff; e_in = e_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (csr_write) begin
         case (paddr[3:2])
            REG_QA:  qa_in = pwdata;
            REG_QG:  qg_in = pwdata;
            REG_RN:  rn_in = pwdata;
            REG_DT:  dt_in = pwdata;
            default: qa_in = qa_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in = req_angle_meas;
               rate_in = req_gyro_rate;
               step_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_MWAIT;
         ST_MWAIT: begin
            if (mul_done) begin
               case (step_ff)
                  4'd0: angle_in = sat32(64'(angle_ff) + mul_res);
                  4'd1: p_in[0] = sat48(64'(p_ff[0]) + mul_res);
                  4'd2: begin
                     p_in[1] = sat48(64'(p_ff[1]) + mul_res);
                     p_in[2] = sat48(64'(p_ff[2]) + mul_res);
                  end
                  4'd3: p_in[3] = sat48(64'(p_ff[3]) + mul_res);
                  4'd4: p_in[0] = sat48(64'(p_ff[0]) - mul_res);
                  4'd5: p_in[1] = sat48(64'(p_ff[1]) - mul_res);
                  4'd6: p_in[2] = sat48(64'(p_ff[2]) - mul_res);
                  4'd7: p_in[3] = sat48(64'(p_ff[3]) - mul_res);
                  4'd8: angle_in = sat32(64'(angle_ff) + mul_res);
                  4'd9: bias_in = sat32(64'(bias_ff) + mul_res);
                  default: angle_in = angle_ff;
               endcase
               step_in = step_ff + 4'd1;
               if (step_ff == STEP_LAST_PRED) state_in = ST_PREP;
               else if (step_ff == STEP_LAST) state_in = ST_DONE;
               else state_in = ST_MUL;
            end
         end
         ST_PREP: begin
            err_in = 33'(meas_ff) - 33'(angle_ff);
            e_in = e_calc;
            t0_in = p_ff[0];
            t1_in = p_ff[1];
            dsel_in = 1'b0;
            if (e_calc == '0) begin
               // zero innovation variance: gains are zero
               k0_in = '0;
               k1_in = '0;
               step_in = STEP_FIRST_COR;
               state_in = ST_MUL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_done) begin
               if (dsel_ff) begin
                  k1_in = div_res;
                  step_in = STEP_FIRST_COR;
                  state_in = ST_MUL;
               end else begin
                  k0_in = div_res;
                  dsel_in = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = angle_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      meas_ff <= meas_in; rate_ff <= rate_in;
      t0_ff <= t0_in; t1_ff <= t1_in; k0_ff <= k0_in; k1_ff <= k1_in;
      err_ff <= err_in; e_ff <= e_in; rsp_ff <= rsp_in;
      step_ff <= step_in; dsel_ff <= dsel_in;
      if (reset) begin
         qa_ff <= QA_RESET; qg_ff <= QG_RESET; rn_ff <= RN_RESET; dt_ff <= DT_RESET;
         state_ff <= ST_IDLE;
         angle_ff <= '0;
         bias_ff <= '0;
         p_ff[0] <= COV_ONE;
         p_ff[1] <= '0;
         p_ff[2] <= '0;
         p_ff[3] <= COV_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         qa_ff <= qa_in; qg_ff <= qg_in; rn_ff <= rn_in; dt_ff <= dt_in;
         state_ff <= state_in;
         angle_ff <= angle_in;
         bias_ff <= bias_in;
         for (int i = 0; i < 4; i++) p_ff[i] <= p_in[i];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_QA:  prdata = qa_ff;
         REG_QG:  prdata = qg_ff;
         REG_RN:  prdata = rn_ff;
         REG_DT:  prdata = dt_ff;
         default: prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle_est = rsp_ff;

endmodule

FILE: design/agkf_mul.sv
// Shared multiplier: rounded signed product built from 32x32 partial products.
module agkf_mul import agkf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               mul_start,
   input  logic signed [63:0] mul_a,
   input  logic signed [63:0] mul_b,
   input  logic               mul_sh40,
   output logic               mul_done,
   output logic signed [63:0] mul_res
);

   logic [49:0]  ua_ff, ua_in, ub_ff, ub_in;
   logic         neg_ff, neg_in, sh40_ff, sh40_in;
   logic [99:0]  acc_ff, acc_in;
   logic [63:0]  prod_ff, prod_in;
   logic [1:0]   pshift_ff, pshift_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic signed [63:0] res_ff, res_in;

   logic [63:0]  mag_a, mag_b;
   logic [31:0]  a_half, b_half;
   logic [99:0]  shifted, rnd, sum, mag_q;
   logic [62:0]  m63;

   always_comb begin
      mag_a = mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
      mag_b = mul_b[63] ? 64'(-mul_b) : 64'(mul_b);
      a_half = cnt_ff[1] ? {14'd0, ua_ff[49:32]} : ua_ff[31:0];
      b_half = cnt_ff[0] ? {14'd0, ub_ff[49:32]} : ub_ff[31:0];
      prod_in = a_half * b_half;
      case (pshift_ff)
         2'd0:    shifted = {36'd0, prod_ff};
         2'd1:    shifted = {4'd0, prod_ff, 32'd0};
         default: shifted = {prod_ff[35:0], 64'd0};
      endcase
      rnd = sh40_ff ? (100'd1 << 39) : (100'd1 << 31);
      sum = acc_ff + rnd;
      mag_q = sh40_ff ? (sum >> 40) : (sum >> 32);
      m63 = (|mag_q[99:63]) ? {63{1'b1}} : mag_q[62:0];

      ua_in = ua_ff; ub_in = ub_ff; neg_in = neg_ff; sh40_in = sh40_ff;
      acc_in = acc_ff; pshift_in = pshift_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0; res_in = res_ff;
      if (mul_start) begin
         ua_in = mag_a[49:0];
         ub_in = mag_b[49:0];
         neg_in = mul_a[63] ^ mul_b[63];
         sh40_in = mul_sh40;
         acc_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         pshift_in = 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
         if (cnt_ff != 3'd0 && cnt_ff <= 3'd4) acc_in = acc_ff + shifted;
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd5) begin
            res_in = neg_ff ? -$signed({1'b0, m63}) : $signed({1'b0, m63});
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ua_ff <= ua_in; ub_ff <= ub_in; neg_ff <= neg_in; sh40_ff <= sh40_in;
      acc_ff <= acc_in; prod_ff <= prod_in; pshift_ff <= pshift_in;
      cnt_ff <= cnt_in; res_ff <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mul_done = done_ff;
   assign mul_res = res_ff;

endmodule

FILE: design/agkf_div.sv
// Bit-serial restoring divider for the gain: num * 2^40 / den, clamped.
module agkf_div import agkf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    div_start,
   input  logic signed [COV_W-1:0] div_num,
   input  logic signed [COV_W:0]   div_den,
   output logic                    div_done,
   output logic signed [COV_W-1:0] div_res
);

   localparam int ITER = COV_FRAC + COV_W;

   logic [COV_W-1:0] num_ff, num_in, q_ff, q_in;
   logic [COV_W:0]   d_ff, d_in, r_ff, r_in;
   logic             ovf_ff, ovf_in, neg_ff, neg_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic signed [COV_W-1:0] res_ff, res_in;

   logic [COV_W+1:0] r_sh;
   logic             ge;
   logic [COV_W-1:0] qmag;

   always_comb begin
      r_sh = {r_ff, num_ff[COV_W-1]};
      ge = r_sh >= {1'b0, d_ff};
      qmag = '0;

      num_in = num_ff; q_in = q_ff; d_in = d_ff; r_in = r_ff;
      ovf_in = ovf_ff; neg_in = neg_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0; res_in = res_ff;
      if (div_start) begin
         num_in = div_num[COV_W-1] ? COV_W'(-div_num) : COV_W'(div_num);
         d_in = div_den[COV_W] ? (COV_W+1)'(-div_den) : (COV_W+1)'(div_den);
         neg_in = div_num[COV_W-1] ^ div_den[COV_W];
         r_in = '0; q_in = '0; ovf_in = 1'b0; cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[COV_W-2:0], 1'b0};
         r_in = ge ? (COV_W+1)'(r_sh - {1'b0, d_ff}) : r_sh[COV_W:0];
         q_in = {q_ff[COV_W-2:0], ge};
         // anything pushed past the top bit already exceeds the clamp
         ovf_in = ovf_ff | q_ff[COV_W-1];
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(ITER - 1)) begin
            qmag = (ovf_in || q_in[COV_W-1]) ? COV_MAX : q_in;
            res_in = neg_ff ? -$signed(qmag) : $signed(qmag);
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; q_ff <= q_in; d_ff <= d_in; r_ff <= r_in;
      ovf_ff <= ovf_in; neg_ff <= neg_in; cnt_ff <= cnt_in; res_ff <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_done = done_ff;
   assign div_res = res_ff;

endmodule

FILE: design/agkf_checker.sv
// Port-level assertions for the angle/gyro Kalman filter, bound to the top level.
module agkf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_angle_est,
   input logic        pready
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_angle_est))
      else $error("stalled result changed");

   // an accepted request keeps the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request port free right after a request");

   // with no result pending, an accepted request raises no result straight away
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
      else $error("result too early");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind angle_gyro_kalman_filter agkf_checker u_agkf_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_angle_est, .pready
);
